@@ sv/btwt_pkg.sv @@
// shared types and constants of the busy time window tracker
package btwt_pkg;

	localparam int TIME_W    = 63;
	localparam int CFG_W     = 30;
	localparam int LEN_W     = 31;
	localparam int SUM_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET = 2'd1;

	localparam logic [CFG_W-1:0]  WINDOW_RST = 30'd100000000;
	localparam logic [CFG_W-1:0]  BUCKET_RST = 30'd50000000;
	localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

	// one stored period
	typedef struct packed {
		logic [TIME_W-1:0] end_ns;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  busy;
	} period_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELAP,
		ST_CLAMP,
		ST_START,
		ST_TEST,
		ST_WRITE,
		ST_EV_RD,
		ST_EV_CMP,
		ST_SUM,
		ST_DONE
	} btwt_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic calc_elapsed;
		logic clamp;
		logic calc_start;
		logic test_join;
		logic write_upd;
		logic rd_oldest;
		logic ev_cmp;
		logic sum_init;
		logic sum_step;
		logic done;
	} btwt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic count_zero;
		logic evict;
		logic sum_done;
	} btwt_stat_t;

endpackage

@@ sv/busy_time_window_tracker.sv @@
// top level of the busy time window tracker
//
// usage:
// - item channel: drive now_ns and busy_req with start high; the item is
//   taken at a rising edge where start is high and busy is low. busy stays
//   high from the cycle after that edge until the result has been shown.
// - result channel: done is high for exactly one cycle, and window_total_ns,
//   window_busy_ns, busy_total_ns and check_time_ns are valid in that cycle.
//   there is no back-pressure; the receiver takes the result as it comes.
// - configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//   register (0 window length, 1 bucket span), cfg_data is the value. ready
//   is always high; write only while busy is low. other indexes are ignored.
// - an item passes the elapsed, clamp, coalesce test (skipped when the store
//   is empty on arrival), write, eviction and sum steps; no new item is taken
//   before done. the next item can be taken the cycle after done, so the rate is
//   set by the single-port period ring: each eviction check costs a read and
//   a compare, and the window sums read one period per cycle.
// - reset (arst_n low) clears the controller, the period count, the running
//   busy total and the last check time, and loads the register defaults.
//   period entries are not cleared; only counted entries are ever used.
module busy_time_window_tracker
	import btwt_pkg::*;
#(
	parameter int MAX_PERIODS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// item channel
	input  logic                 start,
	output logic                 busy,
	input  logic [TIME_W-1:0]    now_ns,
	input  logic                 busy_req,
	// result channel
	output logic                 done,
	output logic [SUM_W-1:0]     window_total_ns,
	output logic [SUM_W-1:0]     window_busy_ns,
	output logic [TIME_W-1:0]    busy_total_ns,
	output logic [TIME_W-1:0]    check_time_ns,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	btwt_cmd_t  cmd;
	btwt_stat_t stat;

	// registers are plain flops, so a write always lands at once
	assign cfg_ready = 1'b1;

	// sequencer: walks elapsed, coalesce or push, eviction and summing
	btwt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// period ring, running totals and window sums
	btwt_dp #(
		.MAX_PERIODS (MAX_PERIODS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_valid & cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.now_ns          (now_ns),
		.busy_req        (busy_req),
		.window_total_ns (window_total_ns),
		.window_busy_ns  (window_busy_ns),
		.busy_total_ns   (busy_total_ns),
		.check_time_ns   (check_time_ns)
	);

	// result strobe comes from the final controller step
	assign done = cmd.done;

endmodule

@@ sv/btwt_ctrl.sv @@
// sequencing state machine of the busy time window tracker
module btwt_ctrl
	import btwt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  btwt_stat_t stat,
	output btwt_cmd_t  cmd,
	output logic       busy
);

	btwt_state_t state_q;
	btwt_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_ELAP;
				end
			end
			ST_ELAP:  state_d = ST_CLAMP;
			ST_CLAMP: begin
				state_d = stat.count_zero ? ST_WRITE : ST_START;
			end
			ST_START: state_d = ST_TEST;
			ST_TEST:  state_d = ST_WRITE;
			ST_WRITE: state_d = ST_EV_RD;
			ST_EV_RD: begin
				state_d = stat.count_zero ? ST_SUM : ST_EV_CMP;
			end
			ST_EV_CMP: begin
				state_d = stat.evict ? ST_EV_RD : ST_SUM;
			end
			ST_SUM: begin
				if (stat.sum_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.accept = start;
			ST_ELAP:  cmd.calc_elapsed = 1'b1;
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_START: cmd.calc_start = 1'b1;
			ST_TEST:  cmd.test_join = 1'b1;
			ST_WRITE: cmd.write_upd = 1'b1;
			ST_EV_RD: begin
				cmd.rd_oldest = !stat.count_zero;
				cmd.sum_init  = stat.count_zero;
			end
			ST_EV_CMP: begin
				cmd.ev_cmp   = 1'b1;
				cmd.sum_init = !stat.evict;
			end
			ST_SUM:  cmd.sum_step = 1'b1;
			ST_DONE: cmd.done = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

@@ sv/btwt_dp.sv @@
// datapath of the busy time window tracker: period ring, counters, arithmetic
module btwt_dp
	import btwt_pkg::*;
#(
	parameter int MAX_PERIODS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btwt_cmd_t            cmd,
	output btwt_stat_t           stat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [TIME_W-1:0]    now_ns,
	input  logic                 busy_req,
	output logic [SUM_W-1:0]     window_total_ns,
	output logic [SUM_W-1:0]     window_busy_ns,
	output logic [TIME_W-1:0]    busy_total_ns,
	output logic [TIME_W-1:0]    check_time_ns
);

	localparam int SW = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
	localparam int CW = $clog2(MAX_PERIODS + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_PERIODS - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_PERIODS);

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	period_t mem [MAX_PERIODS];

	// control state
	logic [CFG_W-1:0]  window_q;
	logic [CFG_W-1:0]  bucket_q;
	logic [CW-1:0]     count_q;
	logic [SW-1:0]     oldest_q;
	logic [SW-1:0]     newest_q;
	logic [TIME_W-1:0] last_check_q;
	logic              prev_busy_q;
	logic [TIME_W-1:0] busy_total_q;
	logic [SW-1:0]     sweep_ptr_q;
	logic [CW-1:0]     sweep_left_q;
	logic              sweep_pend_q;

	// payload registers
	logic [TIME_W-1:0] now_q;
	logic              req_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [CFG_W-1:0]  clamp_q;
	logic [CFG_W-1:0]  busy_part_q;
	logic [TIME_W-1:0] start_q;
	logic              join_q;
	period_t           rdata_q;
	logic [SUM_W-1:0]  sum_total_q;
	logic [SUM_W-1:0]  sum_busy_q;

	// combinational helpers
	logic              rd_en;
	logic [SW-1:0]     rd_addr;
	logic              wr_en;
	logic [SW-1:0]     wr_addr;
	period_t           wr_data;
	logic              full;
	logic [TIME_W:0]   bt_sum;
	logic [LEN_W:0]    join_len;
	logic [LEN_W:0]    join_busy;
	logic [TIME_W:0]   ev_diff;
	logic [TIME_W:0]   tst_diff;
	logic [SUM_W:0]    acc_total;
	logic [SUM_W:0]    acc_busy;

	assign full = (count_q == FULL_CNT);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = newest_q;
		if (cmd.clamp) begin
			rd_en   = 1'b1;
			rd_addr = newest_q;
		end else if (cmd.rd_oldest) begin
			rd_en   = 1'b1;
			rd_addr = oldest_q;
		end else if (cmd.sum_step && sweep_left_q != '0) begin
			rd_en   = 1'b1;
			rd_addr = sweep_ptr_q;
		end
	end

	assign join_len  = {1'b0, rdata_q.len} + {2'b0, clamp_q};
	assign join_busy = {1'b0, rdata_q.busy} + {2'b0, busy_part_q};

	always_comb begin
		wr_en = cmd.write_upd;
		if (join_q) begin
			wr_addr        = newest_q;
			wr_data.end_ns = now_q;
			wr_data.len    = join_len[LEN_W] ? LEN_MAX : join_len[LEN_W-1:0];
			wr_data.busy   = join_busy[LEN_W] ? LEN_MAX : join_busy[LEN_W-1:0];
		end else begin
			wr_addr        = (count_q == '0) ? oldest_q : slot_inc(newest_q);
			wr_data.end_ns = now_q;
			wr_data.len    = {1'b0, clamp_q};
			wr_data.busy   = {1'b0, busy_part_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign bt_sum    = {1'b0, busy_total_q} + {1'b0, elapsed_q};
	assign ev_diff   = {1'b0, now_q} - {1'b0, rdata_q.end_ns};
	assign tst_diff  = {1'b0, now_q} - {1'b0, start_q};
	assign acc_total = {1'b0, sum_total_q} + {2'b0, rdata_q.len};
	assign acc_busy  = {1'b0, sum_busy_q} + {2'b0, rdata_q.busy};

	assign stat.count_zero = (count_q == '0);
	assign stat.evict      = !ev_diff[TIME_W]
		&& (ev_diff[TIME_W-1:0] > {{(TIME_W-CFG_W){1'b0}}, window_q});
	assign stat.sum_done   = (sweep_left_q == '0) && !sweep_pend_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RST;
			bucket_q     <= BUCKET_RST;
			count_q      <= '0;
			oldest_q     <= '0;
			newest_q     <= '0;
			last_check_q <= '0;
			prev_busy_q  <= 1'b0;
			busy_total_q <= '0;
			sweep_ptr_q  <= '0;
			sweep_left_q <= '0;
			sweep_pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW: window_q <= cfg_data;
					CFG_BUCKET: bucket_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clamp && req_q) begin
				busy_total_q <= bt_sum[TIME_W] ? TIME_MAX : bt_sum[TIME_W-1:0];
			end
			if (cmd.write_upd && !join_q) begin
				newest_q <= wr_addr;
				if (full) begin
					oldest_q <= slot_inc(oldest_q);
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.ev_cmp && stat.evict) begin
				oldest_q <= slot_inc(oldest_q);
				count_q  <= count_q - 1'b1;
			end
			if (cmd.sum_init) begin
				sweep_ptr_q  <= oldest_q;
				sweep_left_q <= count_q;
				sweep_pend_q <= 1'b0;
			end else if (cmd.sum_step) begin
				sweep_pend_q <= (sweep_left_q != '0);
				if (sweep_left_q != '0) begin
					sweep_ptr_q  <= slot_inc(sweep_ptr_q);
					sweep_left_q <= sweep_left_q - 1'b1;
				end
			end
			if (cmd.done) begin
				last_check_q <= now_q;
				prev_busy_q  <= req_q;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q <= now_ns;
			req_q <= busy_req;
		end
		if (cmd.calc_elapsed) begin
			elapsed_q <= (now_q > last_check_q) ? now_q - last_check_q : '0;
		end
		if (cmd.clamp) begin
			join_q <= 1'b0;
			if (elapsed_q > {{(TIME_W-CFG_W){1'b0}}, window_q}) begin
				clamp_q     <= window_q;
				busy_part_q <= prev_busy_q ? window_q : '0;
			end else begin
				clamp_q     <= elapsed_q[CFG_W-1:0];
				busy_part_q <= prev_busy_q ? elapsed_q[CFG_W-1:0] : '0;
			end
		end
		if (cmd.calc_start) begin
			start_q <= (rdata_q.end_ns > {{(TIME_W-LEN_W){1'b0}}, rdata_q.len})
				? rdata_q.end_ns - {{(TIME_W-LEN_W){1'b0}}, rdata_q.len} : '0;
		end
		if (cmd.test_join) begin
			// a start ahead of now counts as zero time since start
			join_q <= ((tst_diff[TIME_W] ? '0 : tst_diff[TIME_W-1:0])
				< {{(TIME_W-CFG_W){1'b0}}, bucket_q});
		end
		if (cmd.sum_init) begin
			sum_total_q <= '0;
			sum_busy_q  <= '0;
		end else if (cmd.sum_step && sweep_pend_q) begin
			sum_total_q <= acc_total[SUM_W] ? SUM_MAX : acc_total[SUM_W-1:0];
			sum_busy_q  <= acc_busy[SUM_W] ? SUM_MAX : acc_busy[SUM_W-1:0];
		end
	end

	assign window_total_ns = sum_total_q;
	assign window_busy_ns  = sum_busy_q;
	assign busy_total_ns   = busy_total_q;
	assign check_time_ns   = now_q;

endmodule

@@ sv/btwt_checker.sv @@
// port-level checker of the busy time window tracker and its bind
module btwt_checker
	import btwt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [SUM_W-1:0]     window_total_ns,
	input logic [SUM_W-1:0]     window_busy_ns
);

	// a result only shows while an item is in work
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without an item in work");

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item taken but block not busy");

	// single-cycle strobe, then ready for the next item
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe not followed by idle");

	// busy time in the window never exceeds the window length sum
	a_busy_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (window_busy_ns <= window_total_ns))
		else $error("window busy sum above window total");

endmodule

bind busy_time_window_tracker btwt_checker u_btwt_checker (.*);

@@ tb/busy_time_window_tracker_tb.sv @@
// self-checking testbench of the busy time window tracker: directed and random updates
module busy_time_window_tracker_tb
	import btwt_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH      = 8;
	localparam int DRAIN_CYCLES    = 40;
	localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before the run is declared hung
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int LAST_PHASE      = PHASES - 1;

	localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};
	localparam logic [CFG_IDX_W-1:0] CFG_STRAY_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STRAY_B = 2'd3;
	localparam logic [TIME_W-1:0] ONE_SEC = 63'd1000000000;
	localparam logic [TIME_W-1:0] HALF_SPAN = 63'h4000_0000_0000_0000;

	// one expected result
	typedef struct packed {
		logic [SUM_W-1:0]  total_ns;
		logic [SUM_W-1:0]  busy_ns;
		logic [TIME_W-1:0] busy_total;
		logic [TIME_W-1:0] check_ns;
	} window_report_t;

	// block ports, all inputs known from time zero
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	logic [TIME_W-1:0]    now_ns    = '0;
	logic                 busy_req  = 1'b0;
	logic                 done;
	logic [SUM_W-1:0]     window_total_ns;
	logic [SUM_W-1:0]     window_busy_ns;
	logic [TIME_W-1:0]    busy_total_ns;
	logic [TIME_W-1:0]    check_time_ns;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// tracker state kept by the testbench, at the reset values
	logic [TIME_W-1:0] ring_end  [RING_DEPTH];
	logic [LEN_W-1:0]  ring_len  [RING_DEPTH];
	logic [LEN_W-1:0]  ring_busy [RING_DEPTH];
	int                ring_count  = 0;
	int                ring_oldest = 0;
	logic [TIME_W-1:0] last_seen   = '0;
	logic              was_busy    = 1'b0;
	logic [TIME_W-1:0] busy_accum  = '0;
	logic [CFG_W-1:0]  window_cfg  = WINDOW_RST;
	logic [CFG_W-1:0]  bucket_cfg  = BUCKET_RST;

	window_report_t pending_reports [$];
	int             mismatch_count = 0;

	always #4 clk = ~clk;

	busy_time_window_tracker #(
		.MAX_PERIODS(RING_DEPTH)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.now_ns          (now_ns),
		.busy_req        (busy_req),
		.done            (done),
		.window_total_ns (window_total_ns),
		.window_busy_ns  (window_busy_ns),
		.busy_total_ns   (busy_total_ns),
		.check_time_ns   (check_time_ns),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// time differences never go below zero
	function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
		return (a > b) ? a - b : 64'd0;
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
		logic [63:0] s;
		s = a + b;
		return (s > cap) ? cap : s;
	endfunction

	// one update of the tracker: returns the result it reports
	function automatic window_report_t track_update(logic [TIME_W-1:0] now, logic req);
		logic [63:0]    elapsed;
		logic [63:0]    busy_part;
		logic [63:0]    start_ns;
		logic [63:0]    sum_len;
		logic [63:0]    sum_busy;
		logic           joined;
		int             slot;
		int             k;
		window_report_t rep;

		elapsed = sat_sub(64'(now), 64'(last_seen));
		// the running total takes the unclamped interval, and only when the new request is busy
		if (req)
			busy_accum = TIME_W'(add_sat(64'(busy_accum), elapsed, 64'(TIME_MAX)));
		if (elapsed > 64'(window_cfg))
			elapsed = 64'(window_cfg);
		busy_part = was_busy ? elapsed : 64'd0;

		// coalesce into the newest period when it started less than a bucket ago
		joined = 1'b0;
		if (ring_count > 0) begin
			slot = (ring_oldest + ring_count - 1) % RING_DEPTH;
			start_ns = sat_sub(64'(ring_end[slot]), 64'(ring_len[slot]));
			if (sat_sub(64'(now), start_ns) < 64'(bucket_cfg)) begin
				joined = 1'b1;
				ring_end[slot]  = now;
				ring_len[slot]  = LEN_W'(add_sat(64'(ring_len[slot]), elapsed, 64'(LEN_MAX)));
				ring_busy[slot] = LEN_W'(add_sat(64'(ring_busy[slot]), busy_part,
					64'(LEN_MAX)));
			end
		end

		// otherwise open a new period, dropping the oldest when the ring is full
		if (!joined) begin
			if (ring_count >= RING_DEPTH) begin
				ring_oldest = (ring_oldest + 1) % RING_DEPTH;
				ring_count  = RING_DEPTH - 1;
			end
			slot = (ring_oldest + ring_count) % RING_DEPTH;
			ring_end[slot]  = now;
			ring_len[slot]  = elapsed[LEN_W-1:0];
			ring_busy[slot] = busy_part[LEN_W-1:0];
			ring_count++;
		end

		// evict periods that ended more than a window ago
		while (ring_count > 0
			&& sat_sub(64'(now), 64'(ring_end[ring_oldest])) > 64'(window_cfg)) begin
			ring_oldest = (ring_oldest + 1) % RING_DEPTH;
			ring_count--;
		end

		sum_len  = '0;
		sum_busy = '0;
		for (k = 0; k < ring_count; k++) begin
			slot     = (ring_oldest + k) % RING_DEPTH;
			sum_len  = add_sat(sum_len, 64'(ring_len[slot]), 64'(SUM_MAX));
			sum_busy = add_sat(sum_busy, 64'(ring_busy[slot]), 64'(SUM_MAX));
		end

		last_seen = now;
		was_busy  = req;

		rep.total_ns   = sum_len[SUM_W-1:0];
		rep.busy_ns    = sum_busy[SUM_W-1:0];
		rep.busy_total = busy_accum;
		rep.check_ns   = now;
		return rep;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// results cannot be held off: compare each one against the oldest expectation
	always @(posedge clk) begin : report_check
		window_report_t want;
		if (done === 1'b1) begin
			if (pending_reports.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with no update pending, expected none, got check_time %0d",
					$time, check_time_ns);
			end else begin
				want = pending_reports[0];
				pending_reports.delete(0);
				check_field("window_total_ns", 64'(want.total_ns), 64'(window_total_ns));
				check_field("window_busy_ns", 64'(want.busy_ns), 64'(window_busy_ns));
				check_field("busy_total_ns", 64'(want.busy_total), 64'(busy_total_ns));
				check_field("check_time_ns", 64'(want.check_ns), 64'(check_time_ns));
			end
		end
	end

	// hang detection: counts cycles where no item, result or register write moves
	initial begin : watchdog
		int quiet;
		quiet = 0;
		do begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end while (quiet < WATCHDOG_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// present one update and hold it until the block takes it; start stays high
	// afterwards so that a following item can go out without a gap
	task automatic send_update(logic [TIME_W-1:0] stamp, logic req);
		start    <= 1'b1;
		now_ns   <= stamp;
		busy_req <= req;
		do @(posedge clk); while (busy !== 1'b0);
		pending_reports = {pending_reports, track_update(stamp, req)};
	endtask

	task automatic pause_sender(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// wait until every result is in and the block has had time to go idle
	task automatic settle_block();
		start <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// valid is left high; the caller lowers it after its last write
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			CFG_WINDOW: window_cfg = value;
			CFG_BUCKET: bucket_cfg = value;
			default: ;  // other indexes are ignored by the block
		endcase
	endtask

	task automatic apply_config(logic [CFG_W-1:0] win, logic [CFG_W-1:0] bucket);
		settle_block();
		write_register(CFG_WINDOW, win);
		write_register(CFG_BUCKET, bucket);
		cfg_valid <= 1'b0;
	endtask

	// register defaults: a join within the bucket, then a clamped interval that evicts
	task automatic test_reset_defaults();
		send_update(63'd30000000, 1'b1);
		send_update(63'd45000000, 1'b1);
		send_update(63'd400000000, 1'b0);
	endtask

	// saw-tooth times near zero keep the period start pinned at zero, so period
	// lengths and busy sums saturate and the window sums saturate as well
	task automatic test_length_saturation();
		int i;
		apply_config(CFG_MAX, CFG_MAX);
		for (i = 0; i < 5; i++)
			send_update((i % 2) ? 63'd0 : ONE_SEC, 1'b1);
		// zero bucket never coalesces: a fresh period at time zero
		apply_config(CFG_MAX, '0);
		send_update(63'd0, 1'b1);
		apply_config(CFG_MAX, CFG_MAX);
		for (i = 0; i < 5; i++)
			send_update((i % 2) ? 63'd0 : ONE_SEC, 1'b1);
		apply_config(CFG_MAX, '0);
		send_update(2 * ONE_SEC, 1'b1);
	endtask

	// huge intervals drive the running busy total into saturation; time also goes back
	task automatic test_busy_total_cap();
		send_update(HALF_SPAN, 1'b1);
		send_update(63'd0, 1'b1);
		send_update(TIME_MAX, 1'b1);
	endtask

	// more periods than ring slots inside one window: the oldest gets dropped
	task automatic test_ring_overflow();
		int k;
		apply_config(30'd1000, 30'd1);
		for (k = 1; k <= 9; k++)
			send_update(63'd5000 + 3 * k, k[0]);
	endtask

	// zero window clamps every interval and evicts everything that ended earlier;
	// writes to unused indexes must leave both registers alone
	task automatic test_zero_window_stray_index();
		settle_block();
		write_register(CFG_WINDOW, '0);
		write_register(CFG_STRAY_A, CFG_MAX);
		write_register(CFG_STRAY_B, 30'h1555_5555);
		cfg_valid <= 1'b0;
		send_update(63'd6000, 1'b1);
		send_update(63'd6000, 1'b0);
	endtask

	// random updates under a series of register settings; steps are scaled to the
	// bucket and window so that joins, new periods and evictions all happen
	task automatic test_random_traffic();
		int          phase;
		int          n;
		int          pick;
		logic [63:0] cursor;
		logic        busy_flag;

		busy_flag = 1'b0;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: apply_config(WINDOW_RST, BUCKET_RST);
				1: apply_config(30'd1000, 30'd100);
				2: apply_config(30'd1000, 30'd1);
				3: apply_config(CFG_MAX, CFG_MAX);
				4: apply_config(30'd1, 30'd1);
				5: apply_config('0, '0);
				6: apply_config(30'd500, 30'd2000);
				default: apply_config(CFG_W'($urandom_range(1, 200000)),
					CFG_W'($urandom_range(0, 100000)));
			endcase
			cursor = 64'(last_seen);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45)
					cursor = cursor + $urandom_range(0, bucket_cfg + 4);
				else if (pick < 75)
					cursor = cursor + $urandom_range(0, 2 * window_cfg + 4);
				// 75..84 repeats the same time
				else if (pick >= 85 && pick < 93)
					cursor = sat_sub(cursor, 64'($urandom_range(0, bucket_cfg + 4)));
				else if (pick >= 93 && pick < 98)
					cursor = cursor + {$urandom_range(0, 255), $urandom};
				else if (pick >= 98)
					cursor = {$urandom, $urandom} & 64'(TIME_MAX);
				if (cursor > 64'(TIME_MAX))
					cursor = 64'(TIME_MAX);
				if ($urandom_range(0, 9) < 3)
					busy_flag = ~busy_flag;
				send_update(cursor[TIME_W-1:0], busy_flag);
				// sender gaps everywhere but the last phase
				if (phase < LAST_PHASE && $urandom_range(0, 5) == 0)
					pause_sender($urandom_range(1, 18));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_length_saturation();
		test_busy_total_cap();
		test_ring_overflow();
		test_zero_window_stray_index();
		test_random_traffic();

		settle_block();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/btwt_pkg.sv
sv/btwt_ctrl.sv
sv/btwt_dp.sv
sv/busy_time_window_tracker.sv
sv/btwt_checker.sv
tb/busy_time_window_tracker_tb.sv
